// ===== rtl/swqt_pkg.sv =====
// Package for the semaphore wait queue table: sizes, operation and status codes.
// No dependencies.
`default_nettype none
package swqt_pkg;
  localparam int NUM_SLOTS = 32;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int PROC_COUNT = 32;
  localparam int PROC_W = 5;
  localparam int KEY_W = 32;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE_HEAD = 2'd1;
  localparam logic [1:0] KIND_OUT = 2'd2;
  localparam logic [1:0] KIND_PEEK = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BLOCKED = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic proc_valid;
    logic [PROC_W-1:0] proc_out;
  } result_t;
endpackage
`default_nettype wire

// ===== rtl/semaphore_wait_queue_table.sv =====
// Semaphore wait queue table: a pool of descriptors, each a key and a FIFO of processes.
// Key and link stores live in synchronous memories; depends on swqt_pkg.
//
// One item is processed at a time. The key search sweeps the key memory one
// descriptor per cycle for a peek, an insert or a remove of the head; a remove
// of the head then reads and unlinks the head process. A remove of a given
// process skips the search and unlinks it, and an insert of a blocked process
// or a remove of a process that is not blocked is answered without either. The
// result waits in an output register while the next item is accepted and
// processed; a finished item stalls only while that register is still full.
// Descriptor activity and process-blocked flags are flip-flops cleared by
// reset; the other stores need no clearing.
`default_nettype none
module semaphore_wait_queue_table (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [39:0] s_tdata, // kind[1:0], sem_key[33:2], proc_id[38:34], zero pad
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [7:0] m_tdata // status[1:0], proc_valid[2], proc_out[7:3]
);
  import swqt_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_SCANW = 4'd2, S_DEC = 4'd3,
    S_RDD = 4'd4, S_RDDW = 4'd5, S_UNL = 4'd6, S_UNLW = 4'd7, S_UNLX = 4'd8,
    S_DONE = 4'd9;

  logic [3:0] state;
  logic [1:0] kind;
  logic [KEY_W-1:0] key;
  logic [PROC_W-1:0] pid;
  logic [NUM_SLOTS-1:0] active;
  logic [PROC_COUNT-1:0] blocked;
  logic [SLOT_W:0] scan;
  logic [SLOT_W-1:0] scan_rd;
  logic scan_rd_v;
  logic found;
  logic [SLOT_W-1:0] fdesc;
  logic [PROC_W-1:0] up;
  logic [SLOT_W-1:0] ud;
  result_t res;
  result_t res_out;
  logic out_full;

  logic [KEY_W-1:0] key_mem [NUM_SLOTS];
  logic [PROC_W-1:0] head_mem [NUM_SLOTS];
  logic [PROC_W-1:0] tail_mem [NUM_SLOTS];
  logic [SLOT_W-1:0] pdesc_mem [PROC_COUNT];
  logic [PROC_W-1:0] next_mem [PROC_COUNT];
  logic [PROC_W-1:0] prev_mem [PROC_COUNT];

  logic [KEY_W-1:0] key_q;
  logic [PROC_W-1:0] head_q, tail_q, next_q, prev_q;
  logic [SLOT_W-1:0] pdesc_q;
  logic [SLOT_W-1:0] drd;
  logic [PROC_W-1:0] prd;

  logic free_any;
  logic [SLOT_W-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    drd = fdesc;
    prd = up;
    if (state == S_SCAN) drd = scan[SLOT_W-1:0];
    if (state == S_SCANW && !found && active[scan_rd] && key_q == key) drd = scan_rd;
    if (state == S_RDD) drd = pdesc_q;
  end

  always_ff @(posedge clk) begin
    key_q <= key_mem[drd];
    head_q <= head_mem[drd];
    tail_q <= tail_mem[drd];
    pdesc_q <= pdesc_mem[prd];
    next_q <= next_mem[prd];
    prev_q <= prev_mem[prd];
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_full;
  assign m_tdata = {res_out.proc_out, res_out.proc_valid, res_out.status};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active <= '0;
      blocked <= '0;
      out_full <= 1'b0;
      found <= 1'b0;
      scan <= '0;
      scan_rd_v <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_full || m_tready)) out_full <= 1'b1;
      else if (m_tvalid && m_tready) out_full <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            kind <= s_tdata[1:0];
            key <= s_tdata[33:2];
            pid <= s_tdata[38:34];
            up <= s_tdata[38:34];
            found <= 1'b0;
            scan <= '0;
            scan_rd_v <= 1'b0;
            if (s_tdata[1:0] == KIND_OUT) begin
              if (!blocked[s_tdata[38:34]]) begin
                res <= '{ST_NOT_FOUND, 1'b0, '0};
                state <= S_DONE;
              end else state <= S_RDD;
            end else if (s_tdata[1:0] == KIND_INSERT && blocked[s_tdata[38:34]]) begin
              res <= '{ST_BLOCKED, 1'b0, '0};
              state <= S_DONE;
            end else state <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_rd <= scan[SLOT_W-1:0];
          scan_rd_v <= 1'b1;
          if (scan_rd_v && !found && active[scan_rd] && key_q == key) begin
            found <= 1'b1;
            fdesc <= scan_rd;
          end
          if (scan == (SLOT_W+1)'(NUM_SLOTS - 1)) state <= S_SCANW;
          scan <= scan + 1'b1;
        end
        S_SCANW: begin
          if (!found && active[scan_rd] && key_q == key) begin
            found <= 1'b1;
            fdesc <= scan_rd;
          end
          state <= S_DEC;
        end
        S_DEC: begin
          if (kind == KIND_INSERT) begin
            if (found) begin
              tail_mem[fdesc] <= pid;
              next_mem[tail_q] <= pid;
              prev_mem[pid] <= tail_q;
              pdesc_mem[pid] <= fdesc;
              blocked[pid] <= 1'b1;
              res <= '{ST_OK, 1'b0, '0};
            end else if (free_any) begin
              active[free_idx] <= 1'b1;
              key_mem[free_idx] <= key;
              head_mem[free_idx] <= pid;
              tail_mem[free_idx] <= pid;
              pdesc_mem[pid] <= free_idx;
              blocked[pid] <= 1'b1;
              res <= '{ST_OK, 1'b0, '0};
            end else res <= '{ST_NO_FREE, 1'b0, '0};
            state <= S_DONE;
          end else if (!found) begin
            res <= '{ST_NOT_FOUND, 1'b0, '0};
            state <= S_DONE;
          end else begin
            res <= '{ST_OK, 1'b1, head_q};
            if (kind == KIND_REMOVE_HEAD) begin
              up <= head_q;
              state <= S_RDD;
            end else state <= S_DONE;
          end
        end
        S_RDD: state <= S_RDDW;
        S_RDDW: begin
          ud <= pdesc_q;
          fdesc <= pdesc_q;
          state <= S_UNL;
        end
        S_UNL: state <= S_UNLW;
        S_UNLW: state <= S_UNLX;
        S_UNLX: begin
          if (head_q == up && tail_q == up) active[ud] <= 1'b0;
          else if (head_q == up) head_mem[ud] <= next_q;
          else if (tail_q == up) tail_mem[ud] <= prev_q;
          else begin
            next_mem[prev_q] <= next_q;
            prev_mem[next_q] <= prev_q;
          end
          blocked[up] <= 1'b0;
          if (kind == KIND_OUT) res <= '{ST_OK, 1'b1, up};
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_full || m_tready) begin
            res_out <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a second item while busy");
  a_blk: assert property (@(posedge clk) disable iff (rst)
    state == S_UNLX |=> !blocked[$past(up)])
    else $error("unlinked process still blocked");
endmodule
`default_nettype wire

// ===== bench/semaphore_wait_queue_table_tb.sv =====
// Testbench for the semaphore wait queue table: drives random and directed
// operations over the item streams and checks each result against a predictor.
// Depends on swqt_pkg and the semaphore_wait_queue_table RTL.
`timescale 1ns / 1ps

class swqt_scoreboard;
  bit           act   [swqt_pkg::NUM_SLOTS];
  logic [31:0]  keys  [swqt_pkg::NUM_SLOTS];
  logic [4:0]   heads [swqt_pkg::NUM_SLOTS];
  logic [4:0]   tails [swqt_pkg::NUM_SLOTS];
  bit           blk   [32];
  int           pdesc [32];
  logic [4:0]   nxt   [32];
  logic [4:0]   prv   [32];
  logic [7:0]   pending_results[$];
  int           errors;

  function new();
    errors = 0;
    foreach (act[i]) act[i] = 0;
    foreach (blk[i]) blk[i] = 0;
  endfunction

  function int find_key(logic [31:0] k);
    for (int d = 0; d < swqt_pkg::NUM_SLOTS; d++)
      if (act[d] && keys[d] == k) return d;
    return -1;
  endfunction

  function int find_free();
    for (int d = 0; d < swqt_pkg::NUM_SLOTS; d++)
      if (!act[d]) return d;
    return -1;
  endfunction

  function void unlink(logic [4:0] p);
    int d;
    d = pdesc[p];
    if (heads[d] == p && tails[d] == p) act[d] = 0;
    else if (heads[d] == p) heads[d] = nxt[p];
    else if (tails[d] == p) tails[d] = prv[p];
    else begin
      nxt[prv[p]] = nxt[p];
      prv[nxt[p]] = prv[p];
    end
    blk[p] = 0;
  endfunction

  function void note_op(logic [39:0] item);
    logic [1:0] kind;
    logic [31:0] k;
    logic [4:0] p;
    logic [1:0] st;
    logic v;
    logic [4:0] po;
    int d;
    kind = item[1:0];
    k = item[33:2];
    p = item[38:34];
    st = swqt_pkg::ST_OK;
    v = 0;
    po = 0;
    if (kind == swqt_pkg::KIND_INSERT) begin
      if (blk[p]) st = swqt_pkg::ST_BLOCKED;
      else begin
        d = find_key(k);
        if (d < 0) begin
          d = find_free();
          if (d < 0) st = swqt_pkg::ST_NO_FREE;
          else begin
            act[d] = 1;
            keys[d] = k;
            heads[d] = p;
            tails[d] = p;
          end
        end else begin
          nxt[tails[d]] = p;
          prv[p] = tails[d];
          tails[d] = p;
        end
        if (st == swqt_pkg::ST_OK) begin
          blk[p] = 1;
          pdesc[p] = d;
        end
      end
    end else if (kind == swqt_pkg::KIND_OUT) begin
      if (!blk[p]) st = swqt_pkg::ST_NOT_FOUND;
      else begin
        unlink(p);
        v = 1;
        po = p;
      end
    end else begin
      d = find_key(k);
      if (d < 0) st = swqt_pkg::ST_NOT_FOUND;
      else begin
        po = heads[d];
        if (kind == swqt_pkg::KIND_REMOVE_HEAD) unlink(po);
        v = 1;
      end
    end
    pending_results.push_back({po, v, st});
  endfunction

  function void check_result(logic [7:0] got);
    logic [7:0] exp;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp = pending_results.pop_front();
    if (got[1:0] !== exp[1:0]) begin
      $display("%0t: status expected %0d actual %0d", $time, exp[1:0], got[1:0]);
      errors++;
    end
    if (got[2] !== exp[2]) begin
      $display("%0t: proc_valid expected %0d actual %0d", $time, exp[2], got[2]);
      errors++;
    end
    if (got[7:3] !== exp[7:3]) begin
      $display("%0t: proc_out expected %0d actual %0d", $time, exp[7:3], got[7:3]);
      errors++;
    end
  endfunction
endclass

module semaphore_wait_queue_table_tb;
  import swqt_pkg::*;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [39:0] s_tdata;  // kind, sem_key, proc_id, zero pad
  logic m_tvalid;
  logic m_tready;
  logic [7:0] m_tdata;   // status, proc_valid, proc_out

  swqt_scoreboard queue_model;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  int quiet_cycles;
  logic [31:0] key_pool [8];

  semaphore_wait_queue_table u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) queue_model.check_result(m_tdata);
    if (!rst && s_tvalid && s_tready) queue_model.note_op(s_tdata);
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else if (hold_off) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_op(logic [1:0] kind, logic [31:0] k, logic [4:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {1'b0, p, k, kind};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random(bit noisy);
    logic [31:0] k;
    k = noisy ? $urandom : key_pool[$urandom_range(7)];
    send_op(2'($urandom_range(3)), k, 5'($urandom_range(31)));
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (queue_model.pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    queue_model = new();
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    hold_off = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_op(KIND_PEEK, 32'h0, 5'd0);
    send_op(KIND_REMOVE_HEAD, 32'hFFFF_FFFF, 5'd0);
    send_op(KIND_OUT, 32'h0, 5'd31);
    send_op(KIND_INSERT, 32'hFFFF_FFFF, 5'd31);
    send_op(KIND_INSERT, 32'hFFFF_FFFF, 5'd0);
    send_op(KIND_INSERT, 32'h0, 5'd31);
    send_op(KIND_INSERT, 32'hFFFF_FFFF, 5'd5);
    send_op(KIND_PEEK, 32'hFFFF_FFFF, 5'd0);
    send_op(KIND_OUT, 32'h0, 5'd0);
    send_op(KIND_REMOVE_HEAD, 32'hFFFF_FFFF, 5'd0);
    send_op(KIND_REMOVE_HEAD, 32'hFFFF_FFFF, 5'd0);
    send_op(KIND_PEEK, 32'hFFFF_FFFF, 5'd0);
    for (int i = 0; i < 32; i++) send_op(KIND_INSERT, 32'(32'h100 + i), 5'(i));
    for (int i = 0; i < 32; i++) send_op(KIND_INSERT, 32'(32'h100 + i), 5'(i));
    for (int i = 0; i < 32; i++) send_op(KIND_OUT, 32'h0, 5'(i));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 67 : 6) : 0;
      recv_stall_pct = (ph == 2) ? 67 : ((ph == 3) ? 6 : 0);
      for (int i = 0; i < 175; i++) send_random(($urandom_range(9) == 0));
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++) send_random(0);
    join
    drain();
    repeat (100) @(posedge clk);
    if (queue_model.errors == 0 && queue_model.pending_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
